@@ rtl/handheld_console_timer_assert.svh @@
// ----------------------------------------------------------------------------
// handheld console timer assertion macros
// shared property forms for the timer block checks
// ----------------------------------------------------------------------------
`ifndef HANDHELD_CONSOLE_TIMER_ASSERT_SVH
`define HANDHELD_CONSOLE_TIMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define HCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer check failed");

// next-cycle implication, sampled on clk, off during reset
`define HCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer check failed");

`endif

@@ rtl/hct_pkg.sv @@
// ----------------------------------------------------------------------------
// hct_pkg
// types, codes and constants of the handheld console timer
// ----------------------------------------------------------------------------
package hct_pkg;

  // default width of the master-clock phase counter
  localparam int PHASE_BITS_DEF = 22;

  // request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // register addresses
  localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
  localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
  localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
  localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

  // read data for an unmapped address
  localparam logic [7:0] OPEN_BUS = 8'hFF;

  // control register fields
  localparam int CTRL_ENABLE_BIT = 2;
  localparam logic [1:0] RATE_1024 = 2'd0;
  localparam logic [1:0] RATE_16   = 2'd1;
  localparam logic [1:0] RATE_64   = 2'd2;
  localparam logic [1:0] RATE_256  = 2'd3;

  // most counter steps one tick request can cause
  localparam logic [4:0] MAX_STEPS = 5'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  tick_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [4:0] overflow_count;
  } out_item_t;

  // boundary crossings of one tick advance
  typedef struct packed {
    logic       div_step;
    logic [4:0] timer_steps;
  } cross_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP,
    ST_DONE
  } state_t;

endpackage

@@ rtl/hct_cross.sv @@
// ----------------------------------------------------------------------------
// hct_cross
// phase advance and boundary crossing counts for one tick request
// ----------------------------------------------------------------------------
module hct_cross import hct_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic [PHASE_BITS-1:0] phase,
  input  logic [7:0]            tick_count,
  input  logic [2:0]            control,
  output logic [PHASE_BITS-1:0] phase_nxt,
  output cross_t                crossing
);

  // room above the sum so every five-bit window exists
  localparam int EXT_BITS = PHASE_BITS + 16;

  logic [PHASE_BITS:0] sum;
  logic [EXT_BITS-1:0] sum_ext;
  logic [EXT_BITS-1:0] base_ext;
  logic [4:0]          cross_16;
  logic [4:0]          cross_64;
  logic [4:0]          cross_256;
  logic [4:0]          cross_1024;
  logic [4:0]          sel_steps;

  // phase plus ticks, carry kept for the crossing counts
  assign sum       = {1'b0, phase} + {{(PHASE_BITS-7){1'b0}}, tick_count};
  assign sum_ext   = {{15{1'b0}}, sum};
  assign base_ext  = {{16{1'b0}}, phase};
  assign phase_nxt = sum[PHASE_BITS-1:0];

  // crossings per period: difference of the quotient windows, at most 16
  assign cross_16   = sum_ext[4 +: 5]  - base_ext[4 +: 5];
  assign cross_64   = sum_ext[6 +: 5]  - base_ext[6 +: 5];
  assign cross_256  = sum_ext[8 +: 5]  - base_ext[8 +: 5];
  assign cross_1024 = sum_ext[10 +: 5] - base_ext[10 +: 5];

  // period select from the control rate field
  always_comb begin
    case (control[1:0])
      RATE_1024: sel_steps = cross_1024;
      RATE_16:   sel_steps = cross_16;
      RATE_64:   sel_steps = cross_64;
      RATE_256:  sel_steps = cross_256;
      default:   sel_steps = cross_1024;
    endcase
  end

  assign crossing.div_step    = cross_256[0];
  assign crossing.timer_steps = control[CTRL_ENABLE_BIT] ? sel_steps : 5'd0;

endmodule

@@ rtl/handheld_console_timer.sv @@
// ----------------------------------------------------------------------------
// handheld_console_timer
// divider, counter, modulo and control registers of a handheld timer
// ----------------------------------------------------------------------------
// Requests come in on in_valid/in_ready/in_data: a tick advance, a bus read
// or a bus write. Each request gives exactly one result on
// out_valid/out_ready/out_data: the read data (0xFF for an unmapped address,
// 0 for other kinds) and the number of counter overflows of a tick.
// After accept a read or write goes through the EXEC and DONE states, and its
// result is then registered for out_valid. A tick also passes one STEP state
// per counter step it causes (N steps, 0 to 16): the counter is stepped one
// step per cycle through a single increment/reload unit.
// in_ready is high only while the sequencer is idle, so one request is in
// work at a time; the result sits in an output register, and the next
// request can be accepted while that result waits for out_ready.
// If the receiver stalls with a result still held, a finished request waits
// in its last state until the output register frees up.
// Synchronous active-low reset clears all timer registers, the phase
// counter and the handshake state; the block is ready the cycle after.
// ----------------------------------------------------------------------------
module handheld_console_timer import hct_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

`include "handheld_console_timer_assert.svh"

  state_t                state_r, state_nxt;
  in_item_t              item_r, item_nxt;
  logic [7:0]            divider_r, divider_nxt;
  logic [7:0]            counter_r, counter_nxt;
  logic [7:0]            modulo_r, modulo_nxt;
  logic [2:0]            control_r, control_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [4:0]            steps_left_r, steps_left_nxt;
  logic [4:0]            ovf_r, ovf_nxt;
  logic [7:0]            rdata_r, rdata_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [PHASE_BITS-1:0] phase_adv;
  cross_t                crossing;
  logic                  accept;
  logic                  load_out;
  logic [7:0]            step_value;
  logic                  step_wrap;

  // crossing counts of the latched tick
  hct_cross #(
    .PHASE_BITS (PHASE_BITS)
  ) u_cross (
    .phase      (phase_r),
    .tick_count (item_r.tick_count),
    .control    (control_r),
    .phase_nxt  (phase_adv),
    .crossing   (crossing)
  );

  // shared counter step unit: reload on wrap, else increment
  assign step_wrap  = (counter_r == 8'hFF);
  assign step_value = step_wrap ? modulo_r : (counter_r + 8'd1);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (item_r.kind == KIND_TICK && crossing.timer_steps != 5'd0) begin
          state_nxt = ST_STEP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_STEP: begin
        if (steps_left_r == 5'd1) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  assign accept = in_valid && in_ready;

  // register datapath
  always_comb begin
    item_nxt       = item_r;
    divider_nxt    = divider_r;
    counter_nxt    = counter_r;
    modulo_nxt     = modulo_r;
    control_nxt    = control_r;
    phase_nxt      = phase_r;
    steps_left_nxt = steps_left_r;
    ovf_nxt        = ovf_r;
    rdata_nxt      = rdata_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (accept) begin
      item_nxt  = in_data;
      ovf_nxt   = 5'd0;
      rdata_nxt = 8'd0;
    end

    if (state_r == ST_EXEC) begin
      case (item_r.kind)
        KIND_TICK: begin
          phase_nxt      = phase_adv;
          divider_nxt    = divider_r + {7'd0, crossing.div_step};
          steps_left_nxt = crossing.timer_steps;
        end
        KIND_READ: begin
          case (item_r.address)
            ADDR_DIVIDER: rdata_nxt = divider_r;
            ADDR_COUNTER: rdata_nxt = counter_r;
            ADDR_MODULO:  rdata_nxt = modulo_r;
            ADDR_CONTROL: rdata_nxt = {5'd0, control_r};
            default:      rdata_nxt = OPEN_BUS;
          endcase
        end
        KIND_WRITE: begin
          case (item_r.address)
            ADDR_DIVIDER: divider_nxt = 8'd0;
            ADDR_COUNTER: counter_nxt = item_r.write_data;
            ADDR_MODULO:  modulo_nxt  = item_r.write_data;
            ADDR_CONTROL: control_nxt = item_r.write_data[2:0];
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // one counter step per cycle
    if (state_r == ST_STEP) begin
      counter_nxt    = step_value;
      ovf_nxt        = ovf_r + {4'd0, step_wrap};
      steps_left_nxt = steps_left_r - 5'd1;
    end

    if (load_out) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.read_data      = rdata_r;
      out_data_nxt.overflow_count = ovf_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      divider_r    <= 8'd0;
      counter_r    <= 8'd0;
      modulo_r     <= 8'd0;
      control_r    <= 3'd0;
      phase_r      <= '0;
      steps_left_r <= 5'd0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      divider_r    <= divider_nxt;
      counter_r    <= counter_nxt;
      modulo_r     <= modulo_nxt;
      control_r    <= control_nxt;
      phase_r      <= phase_nxt;
      steps_left_r <= steps_left_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ovf_r      <= ovf_nxt;
    rdata_r    <= rdata_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `HCT_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_r == ST_EXEC)
  `HCT_ASSERT_NOW(a_steps_range, state_r == ST_STEP,
                  steps_left_r != 5'd0 && steps_left_r <= MAX_STEPS)
  `HCT_ASSERT_NEXT(a_last_step, state_r == ST_STEP && steps_left_r == 5'd1,
                   state_r == ST_DONE)
  `HCT_ASSERT_NOW(a_ovf_range, out_valid_r, out_data_r.overflow_count <= MAX_STEPS)

endmodule
